[rtl/core/assert_macros.svh]
// Assertion helpers, sampled on clk and masked while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain concurrent property
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// overlapping implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

[rtl/core/ccsr_pkg.sv]
`timescale 1ns / 1ps

package ccsr_pkg;

	localparam int PW     = 7;   // clipped pixel coordinate
	localparam int CW     = 10;  // signed working coordinate
	localparam int EXT_W  = 7;
	localparam int SQW    = 14;
	localparam int SYM_W  = 8;
	localparam int QDEPTH = 2;

	localparam logic [SYM_W-1:0] SPACE = 8'd32;

	typedef enum logic [2:0] {
		CMD_SQUARE = 3'd0,
		CMD_CIRCLE = 3'd1,
		CMD_TRI_TL = 3'd2,
		CMD_TRI_BL = 3'd3,
		CMD_TRI_TR = 3'd4,
		CMD_TRI_BR = 3'd5,
		CMD_FILL   = 3'd6,
		CMD_READ   = 3'd7
	} cmd_t;

	typedef enum logic {
		REG_CANVAS_WIDTH  = 1'b0,
		REG_CANVAS_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_SOLID = 2'd0,
		OP_DISC  = 2'd1,
		OP_TRI   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'd0,
		ST_IDLE  = 2'd1,
		ST_SCAN  = 2'd2
	} state_t;

	typedef struct packed {
		op_t                   op;
		logic                  flip_x;
		logic                  flip_y;
		logic                  outside;
		logic [PW-1:0]         x_lo;
		logic [PW-1:0]         x_hi;
		logic [PW-1:0]         y_lo;
		logic [PW-1:0]         y_hi;
		logic signed [CW-1:0]  ax;
		logic signed [CW-1:0]  ay;
		logic [SQW-1:0]        ssq;
		logic [SYM_W-1:0]      sym;
	} job_t;

	typedef struct packed {
		logic [SYM_W-1:0] pixel_symbol;
		logic             outside_canvas;
	} result_t;

endpackage

[rtl/core/char_canvas_shape_rasterizer_top.sv]
`timescale 1ns / 1ps

// Character canvas rasteriser. Command words enter through push/full and are taken
// when push is high and full low. Draw and fill words give no result; a read word
// gives one result word, shown on pixel_symbol/outside_canvas while empty is low
// and taken on pop.
// Canvas size is set through wr_en/wr_index/wr_data (0 width, 1 height); the
// user must write it only while the block is idle; the block does not enforce it.
// After reset the pixel store is swept to spaces, one entry a cycle, through all
// 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) entries (4096 by default); full stays
// high until it ends. Canvas registers reset to 64 by 64.
// A draw is loaded from the command queue, and then each pixel of its clipped
// bounding box is visited in turn by the back end scanner, one pixel a cycle.
// Figures wholly off canvas cost nothing. A read, once the scanner is free and
// its word has room, is registered through rd_s1 and rd_s2 and then written to
// the result queue, whose head drives the result ports.
// A two-word command queue parts the input from the scanner, and a two-word
// result queue parts it from the output. A stalled receiver holds reads once two
// result words are waiting or on their way; commands behind a held read wait in
// order, and full rises when the command queue fills.

`include "assert_macros.svh"

module char_canvas_shape_rasterizer_top #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [2:0]        cmd,
	input  logic signed [7:0] pos_x,
	input  logic signed [7:0] pos_y,
	input  logic [6:0]        extent,
	input  logic [7:0]        symbol,
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        pixel_symbol,
	output logic              outside_canvas,
	input  logic              wr_en,
	input  logic              wr_index,
	input  logic [6:0]        wr_data
);

	import ccsr_pkg::*;

	localparam int JW   = $bits(job_t);
	localparam int RW   = $bits(result_t);
	localparam int CNTW = $clog2(QDEPTH+1);

	job_t            job_in, job_out;
	logic [JW-1:0]   job_out_bits;
	logic            job_push, job_full, job_empty, job_pop;
	logic [CNTW-1:0] job_count;
	logic            clearing;

	result_t         res_in, res_out;
	logic [RW-1:0]   res_out_bits;
	logic            res_push;
	logic            res_full;
	logic [CNTW-1:0] res_count;

	ccsr_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.cmd      (cmd),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.extent   (extent),
		.symbol   (symbol),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.clearing (clearing),
		.q_full   (job_full),
		.q_push   (job_push),
		.q_data   (job_in)
	);

	ccsr_queue #(
		.W     (JW),
		.DEPTH (QDEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_out_bits),
		.empty  (job_empty),
		.count  (job_count)
	);

	assign job_out = job_t'(job_out_bits);

	ccsr_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (job_empty),
		.q_data    (job_out),
		.q_pop     (job_pop),
		.clearing  (clearing),
		.res_count (res_count),
		.res_push  (res_push),
		.res_data  (res_in)
	);

	ccsr_queue #(
		.W     (RW),
		.DEPTH (QDEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out_bits),
		.empty  (empty),
		.count  (res_count)
	);

	assign res_out        = result_t'(res_out_bits);
	assign pixel_symbol   = res_out.pixel_symbol;
	assign outside_canvas = res_out.outside_canvas;

	`ASSERT_IMPLY(a_res_credit, res_push, !res_full, "result queue overrun")
	`ASSERT_IMPLY(a_job_gate, job_push, !job_full && !clearing, "job queued while blocked")
	`ASSERT_CLK(a_job_bound, job_count <= CNTW'(QDEPTH), "job queue count out of range")

endmodule

[rtl/core/ccsr_queue.sv]
`timescale 1ns / 1ps

module ccsr_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [W-1:0]                   wdata,
	output logic                           full,
	input  logic                           pop,
	output logic [W-1:0]                   rdata,
	output logic                           empty,
	output logic [$clog2(DEPTH+1)-1:0]     count
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH+1);

	logic [W-1:0]    store_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = store_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[rtl/core/ccsr_front.sv]
`timescale 1ns / 1ps

module ccsr_front #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         cmd,
	input  logic signed [7:0]  pos_x,
	input  logic signed [7:0]  pos_y,
	input  logic [6:0]         extent,
	input  logic [7:0]         symbol,
	input  logic               wr_en,
	input  logic               wr_index,
	input  logic [6:0]         wr_data,
	input  logic               clearing,
	input  logic               q_full,
	output logic               q_push,
	output ccsr_pkg::job_t     q_data
);

	import ccsr_pkg::*;

	localparam logic signed [CW-1:0] ONE = CW'(1);

	logic [6:0] width_q;
	logic [6:0] height_q;
	logic [6:0] aw;
	logic [6:0] ah;

	logic signed [CW-1:0] cx, cy, se, he;
	logic signed [CW-1:0] awm1, ahm1;
	logic signed [CW-1:0] xl, xh, yl, yh;
	logic signed [CW-1:0] xlc, xhc, ylc, yhc;
	logic signed [CW-1:0] ax, ay;
	logic                 flip_x, flip_y;
	logic                 x_empty, y_empty;
	op_t                  op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd64;
			height_q <= 7'd64;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_CANVAS_WIDTH:  width_q  <= wr_data;
				REG_CANVAS_HEIGHT: height_q <= wr_data;
			endcase
		end
	end

	// active canvas saturates at the store size
	assign aw = ({2'b00, width_q} > 9'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : width_q;
	assign ah = ({2'b00, height_q} > 9'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : height_q;

	assign cx   = CW'(pos_x);
	assign cy   = CW'(pos_y);
	assign se   = $signed({3'b000, extent});
	assign he   = $signed({4'b0000, extent[6:1]});
	assign awm1 = $signed({3'b000, aw}) - ONE;
	assign ahm1 = $signed({3'b000, ah}) - ONE;

	always_comb begin
		xl     = cx - he;
		xh     = cx - he + se - ONE;
		yl     = cy - he;
		yh     = cy - he + se - ONE;
		ax     = cx - he;
		ay     = cy - he;
		flip_x = 1'b0;
		flip_y = 1'b0;
		op     = OP_SOLID;
		unique case (cmd_t'(cmd))
			CMD_SQUARE: begin
				op = OP_SOLID;
			end
			CMD_CIRCLE: begin
				xl = cx - se;
				xh = cx + se;
				yl = cy - se;
				yh = cy + se;
				ax = cx;
				ay = cy;
				op = OP_DISC;
			end
			CMD_TRI_TL: begin
				op = OP_TRI;
			end
			CMD_TRI_BL: begin
				yl     = cy + he - se + ONE;
				yh     = cy + he;
				ay     = cy + he;
				flip_y = 1'b1;
				op     = OP_TRI;
			end
			CMD_TRI_TR: begin
				xl     = cx + he - se + ONE;
				xh     = cx + he;
				ax     = cx + he;
				flip_x = 1'b1;
				op     = OP_TRI;
			end
			CMD_TRI_BR: begin
				xl     = cx + he - se + ONE;
				xh     = cx + he;
				yl     = cy + he - se + ONE;
				yh     = cy + he;
				ax     = cx + he;
				ay     = cy + he;
				flip_x = 1'b1;
				flip_y = 1'b1;
				op     = OP_TRI;
			end
			CMD_FILL: begin
				xl = '0;
				xh = awm1;
				yl = '0;
				yh = ahm1;
				op = OP_SOLID;
			end
			CMD_READ: begin
				xl = cx;
				xh = cx;
				yl = cy;
				yh = cy;
				op = OP_READ;
			end
		endcase
	end

	// clip to the active canvas; an empty span means nothing lands on it
	assign xlc     = (xl < 0) ? '0 : xl;
	assign xhc     = (xh > awm1) ? awm1 : xh;
	assign ylc     = (yl < 0) ? '0 : yl;
	assign yhc     = (yh > ahm1) ? ahm1 : yh;
	assign x_empty = (xhc < xlc);
	assign y_empty = (yhc < ylc);

	assign full   = q_full || clearing;
	assign q_push = push && !full && ((op == OP_READ) || !(x_empty || y_empty));

	always_comb begin
		q_data.op      = op;
		q_data.flip_x  = flip_x;
		q_data.flip_y  = flip_y;
		q_data.outside = x_empty || y_empty;
		q_data.x_lo    = xlc[PW-1:0];
		q_data.x_hi    = xhc[PW-1:0];
		q_data.y_lo    = ylc[PW-1:0];
		q_data.y_hi    = yhc[PW-1:0];
		q_data.ax      = ax;
		q_data.ay      = ay;
		q_data.ssq     = SQW'(extent) * SQW'(extent);
		q_data.sym     = symbol;
	end

endmodule

[rtl/core/ccsr_back.sv]
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ccsr_back #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       q_empty,
	input  ccsr_pkg::job_t                             q_data,
	output logic                                       q_pop,
	output logic                                       clearing,
	input  logic [$clog2(ccsr_pkg::QDEPTH+1)-1:0]      res_count,
	output logic                                       res_push,
	output ccsr_pkg::result_t                          res_data
);

	import ccsr_pkg::*;

	localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int AW    = XW + YW;
	localparam int DEPTH = 2 ** AW;
	localparam int CNTW  = $clog2(QDEPTH+1);

	logic [SYM_W-1:0] mem [DEPTH];

	state_t          state_q, state_d;
	job_t            cur_q;
	logic [PW-1:0]   x_q, y_q, x_d, y_d;
	logic [AW-1:0]   clr_q;
	logic            load, issue, issue_rd, credit_ok;
	logic [CNTW:0]   inflight;

	job_t                  src;
	logic [PW-1:0]         px, py;
	logic signed [CW-1:0]  dx, dy, adx, ady, tu, tv;

	logic                  wr_s1, rd_s1, out_s1, cov_s1;
	logic [AW-1:0]         addr_s1;
	logic [SYM_W-1:0]      sym_s1;
	op_t                   op_s1;
	logic [SQW-1:0]        dxsq_s1, dysq_s1, ssq_s1;
	logic signed [CW-1:0]  tu_s1, tv_s1;

	logic                  rd_s2, out_s2;
	logic [SYM_W-1:0]      rdata_s2;

	assign clearing  = (state_q == ST_CLEAR);
	assign inflight  = (CNTW+1)'(res_count) + (CNTW+1)'(rd_s1) + (CNTW+1)'(rd_s2);
	assign credit_ok = (inflight < (CNTW+1)'(QDEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		x_d      = x_q;
		y_d      = y_q;
		q_pop    = 1'b0;
		load     = 1'b0;
		issue    = 1'b0;
		issue_rd = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!q_empty) begin
					if (q_data.op == OP_READ) begin
						if (credit_ok) begin
							q_pop    = 1'b1;
							issue_rd = 1'b1;
						end
					end else begin
						q_pop   = 1'b1;
						load    = 1'b1;
						x_d     = q_data.x_lo;
						y_d     = q_data.y_lo;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				issue = 1'b1;
				if (x_q == cur_q.x_hi) begin
					x_d = cur_q.x_lo;
					if (y_q == cur_q.y_hi) begin
						state_d = ST_IDLE;
					end else begin
						y_d = y_q + PW'(1);
					end
				end else begin
					x_d = x_q + PW'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_data;
		end
		x_q <= x_d;
		y_q <= y_d;
	end

	// per-pixel terms, registered before the coverage test
	always_comb begin
		src = issue_rd ? q_data : cur_q;
		px  = issue_rd ? q_data.x_lo : x_q;
		py  = issue_rd ? q_data.y_lo : y_q;
		dx  = $signed({{(CW-PW){1'b0}}, px}) - src.ax;
		dy  = $signed({{(CW-PW){1'b0}}, py}) - src.ay;
		adx = (dx < 0) ? -dx : dx;
		ady = (dy < 0) ? -dy : dy;
		tu  = src.flip_x ? -dx : dx;
		tv  = src.flip_y ? -dy : dy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
			rd_s1 <= 1'b0;
			rd_s2 <= 1'b0;
		end else begin
			wr_s1 <= issue;
			rd_s1 <= issue_rd;
			rd_s2 <= rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= {YW'(py), XW'(px)};
		sym_s1  <= src.sym;
		op_s1   <= src.op;
		out_s1  <= src.outside;
		ssq_s1  <= src.ssq;
		dxsq_s1 <= SQW'(adx[EXT_W-1:0]) * SQW'(adx[EXT_W-1:0]);
		dysq_s1 <= SQW'(ady[EXT_W-1:0]) * SQW'(ady[EXT_W-1:0]);
		tu_s1   <= tu;
		tv_s1   <= tv;
		out_s2  <= out_s1;
	end

	always_comb begin
		cov_s1 = 1'b0;
		if (wr_s1) begin
			unique case (op_s1)
				OP_SOLID: cov_s1 = 1'b1;
				OP_DISC:  cov_s1 =
					(({1'b0, dxsq_s1} + {1'b0, dysq_s1}) <= {1'b0, ssq_s1});
				OP_TRI:   cov_s1 = (tu_s1 <= tv_s1);
				OP_READ:  cov_s1 = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			mem[clr_q] <= SPACE;
		end else if (cov_s1) begin
			mem[addr_s1] <= sym_s1;
		end
		rdata_s2 <= mem[addr_s1];
	end

	assign res_push                = rd_s2;
	assign res_data.pixel_symbol   = out_s2 ? SPACE : rdata_s2;
	assign res_data.outside_canvas = out_s2;

	`ASSERT_IMPLY(a_scan_in_box, state_q == ST_SCAN, x_q <= cur_q.x_hi && y_q <= cur_q.y_hi, "scan left the box")
	`ASSERT_IMPLY(a_res_room, res_push, res_count < CNTW'(QDEPTH), "result word with no room")
	`ASSERT_IMPLY(a_pop_idle, q_pop, state_q == ST_IDLE && !q_empty, "job taken while busy")
	`ASSERT_IMPLY(a_clear_quiet, state_q == ST_CLEAR, !(wr_s1 || rd_s1 || rd_s2), "traffic during clear")

endmodule
